FILE: rtl/interval_domain_violation_macros.svh
`ifndef INTERVAL_DOMAIN_VIOLATION_MACROS_SVH
`define INTERVAL_DOMAIN_VIOLATION_MACROS_SVH

// same-cycle implication, off during reset
`define IDV_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("interval_domain_violation: check failed");

// next-cycle implication, off during reset
`define IDV_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("interval_domain_violation: check failed");

`endif

FILE: rtl/idv_pkg.sv
package idv_pkg;

    localparam int MAX_INTERVALS = 16;

    localparam int IDX_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);

    localparam int VAL_W   = 32;
    localparam int ENTRY_W = 4;
    localparam int NEAR_W  = 4;
    localparam int CFG_W   = 5;
    localparam int CMP_W   = (CNT_W > ENTRY_W) ? CNT_W : ENTRY_W;

    localparam int ENTRY_LSB  = 0;
    localparam int LOW_LSB    = ENTRY_LSB + ENTRY_W;
    localparam int HIGH_LSB   = LOW_LSB + VAL_W;
    localparam int SAMPLE_LSB = HIGH_LSB + VAL_W;
    localparam int IN_FIELDS_W = SAMPLE_LSB + VAL_W;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

    localparam int DIST_LSB  = 0;
    localparam int NEAR_LSB  = DIST_LSB + VAL_W;
    localparam int SIDE_LSB  = NEAR_LSB + NEAR_W;
    localparam int OUT_FIELDS_W = SIDE_LSB + 1;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int ADDR_W = 3;
    localparam int APB_W  = 32;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic SIDE_LOW  = 1'b0;
    localparam logic SIDE_HIGH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_MRG
    } state_t;

    typedef struct packed {
        logic             hit;
        logic             below;
        logic             above;
        logic             gap;
        logic [VAL_W-1:0] d_up;
        logic [VAL_W-1:0] d_dn;
    } cell_flags_t;

    typedef struct packed {
        logic [VAL_W-1:0] distance;
        logic [IDX_W-1:0] idx;
        logic             side;
    } merge_res_t;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_W-1:0] c);
        logic [CNT_W-1:0] n;
        if (c == '0)
        begin
            n = CNT_W'(1);
        end
        else if (int'(c) > MAX_INTERVALS)
        begin
            n = CNT_W'(MAX_INTERVALS);
        end
        else
        begin
            n = CNT_W'(c);
        end
        return n;
    endfunction

endpackage

FILE: rtl/idv_cell.sv
module idv_cell
    import idv_pkg::*;
(
    input  logic                    clk,
    input  logic [IDX_W-1:0]        idx,
    input  logic [CNT_W-1:0]        count,
    input  logic                    wr_en,
    input  logic [ENTRY_W-1:0]      wr_index,
    input  logic signed [VAL_W-1:0] wr_low,
    input  logic signed [VAL_W-1:0] wr_high,
    input  logic                    en,
    input  logic signed [VAL_W-1:0] sample,
    input  logic                    below_right,
    output logic                    below,
    output cell_flags_t             flags
);

    logic signed [VAL_W-1:0] low_reg;
    logic signed [VAL_W-1:0] low_next;
    logic signed [VAL_W-1:0] high_reg;
    logic signed [VAL_W-1:0] high_next;
    cell_flags_t             flags_reg;
    cell_flags_t             flags_next;

    logic active;
    logic has_next;
    logic above;

    always_comb
    begin
        low_next  = low_reg;
        high_next = high_reg;
        if (wr_en && (CMP_W'(wr_index) == CMP_W'(idx)))
        begin
            low_next  = wr_low;
            high_next = wr_high;
        end
    end

    // compare the held entry against the sample, gap test uses the right neighbor
    always_comb
    begin
        active   = CNT_W'(idx) < count;
        has_next = (CNT_W'(idx) + CNT_W'(1)) < count;
        below    = sample < low_reg;
        above    = sample > high_reg;

        flags_next = flags_reg;
        if (en)
        begin
            flags_next.hit   = active && !below && !above;
            flags_next.below = below;
            flags_next.above = above;
            flags_next.gap   = has_next && above && below_right;
            flags_next.d_up  = VAL_W'(sample - high_reg);
            flags_next.d_dn  = VAL_W'(low_reg - sample);
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg   <= low_next;
        high_reg  <= high_next;
        flags_reg <= flags_next;
    end

    assign flags = flags_reg;

endmodule

FILE: rtl/idv_merge.sv
module idv_merge
    import idv_pkg::*;
(
    input  cell_flags_t      flags [MAX_INTERVALS],
    input  logic [CNT_W-1:0] count,
    input  logic [IDX_W-1:0] last_nearest,
    input  logic             last_side,
    output merge_res_t       res
);

    logic             last_hit;
    logic             any_in;
    logic             any_gap;
    logic [IDX_W-1:0] first_in;
    logic [IDX_W-1:0] first_gap;
    logic [IDX_W-1:0] gap_up;
    logic [IDX_W-1:0] nm1;
    logic [VAL_W-1:0] d1;
    logic [VAL_W-1:0] d2;

    always_comb
    begin
        last_hit  = (CNT_W'(last_nearest) < count) && flags[last_nearest].hit;
        any_in    = 1'b0;
        any_gap   = 1'b0;
        first_in  = '0;
        first_gap = '0;
        // lowest index wins
        for (int i = MAX_INTERVALS - 1; i >= 0; i--)
        begin
            if (flags[i].hit)
            begin
                any_in   = 1'b1;
                first_in = IDX_W'(i);
            end
            if (flags[i].gap)
            begin
                any_gap   = 1'b1;
                first_gap = IDX_W'(i);
            end
        end

        nm1    = IDX_W'(count - CNT_W'(1));
        gap_up = first_gap + IDX_W'(1);
        d1     = flags[first_gap].d_up;
        d2     = flags[gap_up].d_dn;

        res.distance = '0;
        res.idx      = last_nearest;
        res.side     = last_side;
        if (last_hit)
        begin
            res.idx = last_nearest;
        end
        else if (any_in)
        begin
            res.idx = first_in;
        end
        else if (flags[0].below)
        begin
            res.distance = flags[0].d_dn;
            res.idx      = '0;
            res.side     = SIDE_LOW;
        end
        else if (flags[nm1].above)
        begin
            res.distance = flags[nm1].d_up;
            res.idx      = nm1;
            res.side     = SIDE_HIGH;
        end
        else if (any_gap)
        begin
            // tie goes to the upper interval
            if (d1 < d2)
            begin
                res.distance = d1;
                res.idx      = first_gap;
                res.side     = SIDE_HIGH;
            end
            else
            begin
                res.distance = d2;
                res.idx      = gap_up;
                res.side     = SIDE_LOW;
            end
        end
    end

endmodule

FILE: rtl/interval_domain_violation.sv
// an evaluate request's sample is registered, then its cell flags (compare stage), then its result (merge stage)
// a load writes its entry directly; evaluate requests are taken when idle or as a merge completes, not while comparing
// while a finished result waits on m_tready the merge, and with it the next request, is held
// reset: interval_count = 1, nearest index and side = 0; entries undefined until loaded

`include "interval_domain_violation_macros.svh"

module interval_domain_violation
    import idv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // entry_index, interval_low, interval_high, sample_value, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // op
    input  logic [0:0]            s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // distance, nearest_index, side, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [APB_W-1:0]      pwdata,
    output logic [APB_W-1:0]      prdata,
    output logic                  pready
);

    state_t                  state_reg;
    state_t                  state_next;
    logic                    m_tvalid_reg;
    logic                    m_tvalid_next;
    logic [CFG_W-1:0]        count_reg;
    logic [CFG_W-1:0]        count_next;
    logic [IDX_W-1:0]        last_nearest_reg;
    logic [IDX_W-1:0]        last_nearest_next;
    logic                    last_side_reg;
    logic                    last_side_next;
    logic signed [VAL_W-1:0] sample_reg;
    logic signed [VAL_W-1:0] sample_next;
    logic [VAL_W-1:0]        dist_reg;
    logic [VAL_W-1:0]        dist_next;
    logic [IDX_W-1:0]        near_reg;
    logic [IDX_W-1:0]        near_next;
    logic                    side_reg;
    logic                    side_next;

    logic             out_busy;
    logic             merge_go;
    logic             in_fire;
    logic             eval_fire;
    logic             load_fire;
    logic             cfg_write;
    logic [CNT_W-1:0] n_active;

    cell_flags_t cell_flags [MAX_INTERVALS];
    logic        cell_below [MAX_INTERVALS];
    merge_res_t  merge_res;

    assign n_active  = clamp_count(count_reg);
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[ADDR_W-1] == 1'b0) ? APB_W'(count_reg) : '0;

    always_comb
    begin
        count_next = count_reg;
        if (cfg_write && (paddr[ADDR_W-1] == 1'b0))
        begin
            count_next = pwdata[CFG_W-1:0];
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_INTERVALS; g++)
        begin : g_cell
            logic below_right;
            if (g == MAX_INTERVALS - 1)
            begin : g_end
                assign below_right = 1'b0;
            end
            else
            begin : g_mid
                assign below_right = cell_below[g + 1];
            end

            idv_cell u_cell (
                .clk         (clk),
                .idx         (IDX_W'(g)),
                .count       (n_active),
                .wr_en       (load_fire),
                .wr_index    (s_tdata[ENTRY_LSB +: ENTRY_W]),
                .wr_low      (s_tdata[LOW_LSB +: VAL_W]),
                .wr_high     (s_tdata[HIGH_LSB +: VAL_W]),
                .en          (state_reg == ST_CMP),
                .sample      (sample_reg),
                .below_right (below_right),
                .below       (cell_below[g]),
                .flags       (cell_flags[g])
            );
        end
    endgenerate

    idv_merge u_merge (
        .flags        (cell_flags),
        .count        (n_active),
        .last_nearest (last_nearest_reg),
        .last_side    (last_side_reg),
        .res          (merge_res)
    );

    always_comb
    begin
        out_busy  = m_tvalid_reg && !m_tready;
        merge_go  = (state_reg == ST_MRG) && !out_busy;
        s_tready  = (state_reg == ST_IDLE) || merge_go;
        in_fire   = s_tvalid && s_tready;
        eval_fire = in_fire && (s_tuser[0] == OP_EVAL);
        load_fire = in_fire && (s_tuser[0] == OP_LOAD);

        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (eval_fire)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_MRG;
            end
            ST_MRG:
            begin
                if (merge_go)
                begin
                    state_next = eval_fire ? ST_CMP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        m_tvalid_next     = merge_go || out_busy;
        dist_next         = dist_reg;
        near_next         = near_reg;
        side_next         = side_reg;
        last_nearest_next = last_nearest_reg;
        last_side_next    = last_side_reg;
        if (merge_go)
        begin
            dist_next         = merge_res.distance;
            near_next         = merge_res.idx;
            side_next         = merge_res.side;
            last_nearest_next = merge_res.idx;
            last_side_next    = merge_res.side;
        end

        sample_next = eval_fire ? s_tdata[SAMPLE_LSB +: VAL_W] : sample_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            m_tvalid_reg     <= 1'b0;
            count_reg        <= CFG_W'(1);
            last_nearest_reg <= '0;
            last_side_reg    <= SIDE_LOW;
        end
        else
        begin
            state_reg        <= state_next;
            m_tvalid_reg     <= m_tvalid_next;
            count_reg        <= count_next;
            last_nearest_reg <= last_nearest_next;
            last_side_reg    <= last_side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        dist_reg   <= dist_next;
        near_reg   <= near_next;
        side_reg   <= side_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_DATA_W'({side_reg, NEAR_W'(near_reg), dist_reg});

    `IDV_ASSERT_NXT(a_merge_fills_out, state_reg == ST_MRG && !out_busy, m_tvalid)
    `IDV_ASSERT_NXT(a_eval_starts_cmp, eval_fire, state_reg == ST_CMP)
    `IDV_ASSERT_NXT(a_zero_keeps_side, merge_go && merge_res.distance == '0, $stable(last_side_reg))
    `IDV_ASSERT_IMP(a_cmp_blocks_input, state_reg == ST_CMP, !s_tready)

endmodule
